// ===== rtl/session_hop_route_table_macros.svh =====
// Assertion macros for the route table RTL.
// Used by files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef SESSION_HOP_ROUTE_TABLE_MACROS_SVH
`define SESSION_HOP_ROUTE_TABLE_MACROS_SVH

// same-cycle implication
`define SHRT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("route table check failed");

// next-cycle implication
`define SHRT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("route table check failed");

`endif

// ===== rtl/shrt_pkg.sv =====
// Types and constants shared by the route table modules.
// No dependencies.
package shrt_pkg;

  localparam int NODE_W    = 6;
  localparam int SESS_W    = 32;
  localparam int HOPS_W    = 8;
  localparam int TICK_W    = 32;
  localparam int VIAS_W    = 64;
  localparam int COUNT_W   = 7;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_PURGE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE  = 2'd1;

  localparam logic [NODE_W-1:0] OWN_NODE_RST = 6'd0;
  localparam logic [TICK_W-1:0] MAX_AGE_RST  = 32'd1000;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [NODE_W-1:0] source_node;
    logic [SESS_W-1:0] session;
    logic [HOPS_W-1:0] hop_count;
    logic [NODE_W-1:0] via_node;
    logic [NODE_W-1:0] link_peer;
    logic [NODE_W-1:0] dest_node;
  } route_in_t;

  typedef struct packed {
    logic               accepted;
    logic               deliverable;
    logic [COUNT_W-1:0] purged_count;
  } route_out_t;

  typedef struct packed {
    logic [SESS_W-1:0] session;
    logic [HOPS_W-1:0] hops;
    logic [TICK_W-1:0] stamp;
    logic [VIAS_W-1:0] vias;
  } entry_t;

  typedef struct packed {
    logic [SESS_W-1:0] a;
    logic [SESS_W-1:0] b;
    logic [TICK_W-1:0] thr;
  } cmp_req_t;

  typedef struct packed {
    logic lt;
    logic eq;
    logic ge;
  } cmp_rsp_t;

endpackage

// ===== rtl/shrt_mem.sv =====
// Entry store: one write port, one registered read port.
// Depends on shrt_pkg.
module shrt_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  shrt_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output shrt_pkg::entry_t rd_data
);
  import shrt_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/shrt_cmp.sv =====
// Shared 32-bit compare and age unit: a vs b order, and (a - b) >= thr.
// Depends on shrt_pkg.
module shrt_cmp (
  input  shrt_pkg::cmp_req_t req,
  output shrt_pkg::cmp_rsp_t rsp
);
  import shrt_pkg::*;

  logic [SESS_W-1:0] diff;

  assign diff   = req.a - req.b;
  assign rsp.lt = req.a < req.b;
  assign rsp.eq = req.a == req.b;
  assign rsp.ge = diff >= req.thr;

endmodule

// ===== rtl/session_hop_route_table.sv =====
// Route table top: sequencer, valid bits, config and result register.
// Depends on shrt_pkg, shrt_mem, shrt_cmp and the macros header.
// Update/lookup/unused op: accept moves to ST_ACCESS, which registers out_valid; no new item until idle.
// Purge: one entry per cycle; out_valid is registered after the scan and last age check; no new item until idle.
// A result waiting on out_ready holds the sequencer in its final state.
// Sync reset clears valid bits, tick counter, config (own 0, max age 1000).
`include "session_hop_route_table_macros.svh"

module session_hop_route_table #(
  parameter int NODE_SLOTS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  shrt_pkg::route_in_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output shrt_pkg::route_out_t                out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [shrt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [shrt_pkg::CFG_DAT_W-1:0]      cfg_data
);
  import shrt_pkg::*;

  localparam int IDX_W = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  localparam int CNT_W = $clog2(NODE_SLOTS + 1);
  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(NODE_SLOTS);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ACCESS = 2'd1;
  localparam logic [1:0] ST_PURGE  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  route_in_t             item_r;
  logic [NODE_SLOTS-1:0] valid_r, valid_nxt;
  logic [TICK_W-1:0]     now_r, now_nxt;
  logic [NODE_W-1:0]     own_node_r;
  logic [TICK_W-1:0]     max_age_r;
  logic [CNT_W-1:0]      scan_cnt_r, scan_cnt_nxt;
  logic                  chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]      chk_idx_r, chk_idx_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  route_out_t            out_data_r, out_data_nxt;

  logic                  mem_wr_en, mem_rd_en;
  logic [IDX_W-1:0]      mem_wr_addr, mem_rd_addr;
  entry_t                mem_wr_data, rd;
  cmp_req_t              cmp_req;
  cmp_rsp_t              cmp_rsp;

  logic                  out_free, in_fire;
  logic                  src_in_rng, dest_in_rng;
  logic [IDX_W-1:0]      src_idx, dest_idx;
  logic [VIAS_W-1:0]     via_bit;
  logic                  age_hit;

  shrt_mem #(
    .DEPTH (NODE_SLOTS),
    .AW    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (rd)
  );

  shrt_cmp u_cmp (
    .req (cmp_req),
    .rsp (cmp_rsp)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  assign src_in_rng  = 32'(item_r.source_node) < NODE_SLOTS;
  assign dest_in_rng = 32'(item_r.dest_node) < NODE_SLOTS;
  assign src_idx     = item_r.source_node[IDX_W-1:0];
  assign dest_idx    = item_r.dest_node[IDX_W-1:0];
  assign via_bit     = VIAS_W'(1) << item_r.via_node;

  // one unit serves the session compare and the purge age check
  always_comb begin
    cmp_req.thr = max_age_r;
    if (state_r == ST_PURGE) begin
      cmp_req.a = now_r;
      cmp_req.b = rd.stamp;
    end else begin
      cmp_req.a = item_r.session;
      cmp_req.b = rd.session;
    end
  end

  assign age_hit = chk_vld_r && valid_r[chk_idx_r] && (own_node_r != NODE_W'(chk_idx_r)) &&
                   cmp_rsp.ge;

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    now_nxt       = now_r;
    scan_cnt_nxt  = scan_cnt_r;
    chk_vld_nxt   = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = src_idx;
    mem_wr_data   = rd;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = in_data.source_node[IDX_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.op == OP_PURGE) begin
            state_nxt    = ST_PURGE;
            now_nxt      = now_r + TICK_W'(1);
            scan_cnt_nxt = '0;
            count_nxt    = '0;
          end else begin
            state_nxt = ST_ACCESS;
            mem_rd_en = 1'b1;
            if (in_data.op == OP_LOOKUP) begin
              mem_rd_addr = in_data.dest_node[IDX_W-1:0];
            end
          end
        end
      end

      ST_ACCESS: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          case (item_r.op)
            OP_UPDATE: begin
              if (src_in_rng && !(valid_r[src_idx] && cmp_rsp.lt)) begin
                out_data_nxt.accepted = 1'b1;
                if (!valid_r[src_idx] || !cmp_rsp.eq) begin
                  mem_wr_en          = 1'b1;
                  mem_wr_data        = '{item_r.session, item_r.hop_count, now_r, via_bit};
                  valid_nxt[src_idx] = 1'b1;
                end else if (item_r.hop_count < rd.hops) begin
                  mem_wr_en        = 1'b1;
                  mem_wr_data.hops = item_r.hop_count;
                  mem_wr_data.vias = via_bit;
                end else if (item_r.hop_count == rd.hops) begin
                  mem_wr_en        = 1'b1;
                  mem_wr_data.vias = rd.vias | via_bit;
                end
              end
            end
            OP_LOOKUP: begin
              out_data_nxt.deliverable = (item_r.link_peer == item_r.dest_node) ||
                (dest_in_rng && valid_r[dest_idx] && rd.vias[item_r.link_peer]);
            end
            default: begin
            end
          endcase
        end
      end

      ST_PURGE: begin
        if (scan_cnt_r != SCAN_END) begin
          mem_rd_en    = 1'b1;
          mem_rd_addr  = scan_cnt_r[IDX_W-1:0];
          chk_vld_nxt  = 1'b1;
          chk_idx_nxt  = scan_cnt_r[IDX_W-1:0];
          scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
        end
        if (age_hit) begin
          valid_nxt[chk_idx_r] = 1'b0;
          count_nxt            = count_r + COUNT_W'(1);
        end
        if (scan_cnt_r == SCAN_END && !chk_vld_r && out_free) begin
          state_nxt                 = ST_IDLE;
          out_valid_nxt             = 1'b1;
          out_data_nxt              = '0;
          out_data_nxt.purged_count = count_r;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      now_r       <= '0;
      own_node_r  <= OWN_NODE_RST;
      max_age_r   <= MAX_AGE_RST;
      scan_cnt_r  <= '0;
      chk_vld_r   <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      now_r       <= now_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      chk_vld_r   <= chk_vld_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_OWN_NODE: own_node_r <= cfg_data[NODE_W-1:0];
          CFG_MAX_AGE:  max_age_r  <= cfg_data[TICK_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r  <= chk_idx_nxt;
    out_data_r <= out_data_nxt;
    if (in_fire) begin
      item_r <= in_data;
    end
  end

  `SHRT_ASSERT_IMP(a_one_field, out_valid && out_data.accepted, !out_data.deliverable && (out_data.purged_count == '0))
  `SHRT_ASSERT_IMP(a_count_max, out_valid, 32'(out_data.purged_count) <= NODE_SLOTS)
  `SHRT_ASSERT_IMP(a_scan_max, 1'b1, scan_cnt_r <= SCAN_END)
  `SHRT_ASSERT_NXT(a_no_purge_out, state_r == ST_PURGE && scan_cnt_r != SCAN_END, state_r == ST_PURGE)

endmodule
